// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; each expects aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

// Implication checked in the same cycle.
`define ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("same-cycle check failed");

`endif

// ===== hw/rtl/dnr_pkg.sv =====
package dnr_pkg;

    localparam int LANES  = 4;
    localparam int DATA_W = 8;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + $clog2(LANES);
    localparam int ACC_W  = 32;
    localparam int SHIFT_W = 5;

    localparam int SAT_HIGH = 127;
    localparam int SAT_LOW  = -128;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MULTIPLIER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE         = 2'd2;

    typedef logic signed [PROD_W-1:0] dnr_prod_t;

    // Control of the tile held next to the lane products
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [ACC_W-1:0] bias;
    } dnr_tile_ctl_t;

    // Requantization settings
    typedef struct packed {
        logic [ACC_W-1:0]   multiplier;
        logic [SHIFT_W-1:0] shift;
        logic               relu;
    } dnr_cfg_t;

endpackage

// ===== hw/rtl/int8_dense_neuron_requant_core.sv =====
// A tile marked last reaches m_valid through the lane product registers, the
// accumulator result register, the requantization multiplier stage and the output
// register, each holding one item. Throughput: one tile per cycle while s_ready is
// high; up to four last tiles are absorbed while m_ready is low before s_ready drops.
// Reset: synchronous, active low; clears the accumulator and the pipeline, and sets
// multiplier to 1, shift to 0 and ReLU off.
`include "assert_macros.svh"

module int8_dense_neuron_requant_core
    import dnr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [DATA_W-1:0]    s_weight_lane0,
    input  logic signed [DATA_W-1:0]    s_weight_lane1,
    input  logic signed [DATA_W-1:0]    s_weight_lane2,
    input  logic signed [DATA_W-1:0]    s_weight_lane3,
    input  logic signed [DATA_W-1:0]    s_act_lane0,
    input  logic signed [DATA_W-1:0]    s_act_lane1,
    input  logic signed [DATA_W-1:0]    s_act_lane2,
    input  logic signed [DATA_W-1:0]    s_act_lane3,
    input  logic signed [ACC_W-1:0]     s_neuron_bias,
    input  logic                        s_first_tile,
    input  logic                        s_last_tile,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_neuron_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ACC_W-1:0]            cfg_data
);

    logic signed [DATA_W-1:0] weight [LANES];
    logic signed [DATA_W-1:0] act    [LANES];
    dnr_prod_t                prod   [LANES];
    dnr_tile_ctl_t            tile_reg;
    dnr_tile_ctl_t            tile_next;
    dnr_cfg_t                 cfg_reg;
    logic                     accept;
    logic                     drain;
    logic                     res_valid;
    logic                     res_ready;
    logic [ACC_W-1:0]         res_acc;

    assign weight[0] = s_weight_lane0;
    assign weight[1] = s_weight_lane1;
    assign weight[2] = s_weight_lane2;
    assign weight[3] = s_weight_lane3;
    assign act[0]    = s_act_lane0;
    assign act[1]    = s_act_lane1;
    assign act[2]    = s_act_lane2;
    assign act[3]    = s_act_lane3;

    assign s_ready   = !tile_reg.valid || drain;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.multiplier <= ACC_W'(1);
            cfg_reg.shift      <= '0;
            cfg_reg.relu       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OUTPUT_MULTIPLIER:   cfg_reg.multiplier <= cfg_data;
                CFG_OUTPUT_SHIFT_AMOUNT: cfg_reg.shift      <= cfg_data[SHIFT_W-1:0];
                CFG_RELU_ENABLE:         cfg_reg.relu       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // tile control travels with the lane products
    always_comb begin
        tile_next = tile_reg;
        if (accept) begin
            tile_next.valid = 1'b1;
            tile_next.first = s_first_tile;
            tile_next.last  = s_last_tile;
            tile_next.bias  = s_neuron_bias;
        end else if (drain) begin
            tile_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_reg.valid <= 1'b0;
        end else begin
            tile_reg.valid <= tile_next.valid;
        end
        tile_reg.first <= tile_next.first;
        tile_reg.last  <= tile_next.last;
        tile_reg.bias  <= tile_next.bias;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        dnr_lane u_lane (
            .aclk   (aclk),
            .load   (accept),
            .weight (weight[k]),
            .act    (act[k]),
            .prod   (prod[k])
        );
    end

    dnr_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tile      (tile_reg),
        .prod      (prod),
        .drain     (drain),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_acc   (res_acc)
    );

    dnr_requant u_requant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_acc   (res_acc),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_neuron_out)
    );

    `ASSERT_NEXT(a_accept_fills_stage, accept, tile_reg.valid)
    `ASSERT_SAME(a_drain_needs_tile, drain, tile_reg.valid)

endmodule

// ===== hw/rtl/dnr_lane.sv =====
module dnr_lane
    import dnr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] act,
    output dnr_prod_t                prod
);

    dnr_prod_t prod_reg;
    dnr_prod_t prod_next;

    // one signed 8x8 product per lane
    assign prod_next = weight * act;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/dnr_merge.sv =====
`include "assert_macros.svh"

module dnr_merge
    import dnr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dnr_tile_ctl_t    tile,
    input  dnr_prod_t        prod [LANES],
    output logic             drain,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [ACC_W-1:0] res_acc
);

    logic signed [SUM_W-1:0] lane_sum;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        res_acc_reg;
    logic                    res_valid_reg;
    logic                    res_valid_next;

    // combine the lane products
    always_comb begin
        lane_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            lane_sum = lane_sum + SUM_W'(prod[k]);
        end
    end

    // a last tile waits until the result slot is free
    assign drain    = tile.valid && (!tile.last || !res_valid_reg || res_ready);
    assign acc_next = (tile.first ? tile.bias : acc_reg) + ACC_W'(lane_sum);

    always_comb begin
        res_valid_next = res_valid_reg;
        if (drain && tile.last) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (drain) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (drain && tile.last) begin
            res_acc_reg <= acc_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_acc   = res_acc_reg;

    `ASSERT_NEXT(a_last_gives_result, drain && tile.last, res_valid_reg && res_acc_reg == acc_reg)
    `ASSERT_NEXT(a_result_holds, res_valid_reg && !res_ready, res_valid_reg && $stable(res_acc_reg))

endmodule

// ===== hw/rtl/dnr_requant.sv =====
`include "assert_macros.svh"

module dnr_requant
    import dnr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dnr_cfg_t                 cfg,
    input  logic                     res_valid,
    output logic                     res_ready,
    input  logic [ACC_W-1:0]         res_acc,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_value
);

    logic                     prod_valid_reg;
    logic                     prod_valid_next;
    logic [ACC_W-1:0]         prod_reg;
    logic [ACC_W-1:0]         prod_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;
    logic signed [ACC_W-1:0]  shifted;
    logic                     out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign res_ready = !prod_valid_reg || out_free;

    // multiply, keep the low 32 bits
    assign prod_next = res_acc * cfg.multiplier;

    // shift, optional ReLU, saturate to int8
    assign shifted = $signed(prod_reg) >>> cfg.shift;
    always_comb begin
        priority if (cfg.relu && shifted < 0) begin
            out_value_next = '0;
        end else if (shifted > ACC_W'(SAT_HIGH)) begin
            out_value_next = DATA_W'(SAT_HIGH);
        end else if (shifted < ACC_W'(SAT_LOW)) begin
            out_value_next = DATA_W'(SAT_LOW);
        end else begin
            out_value_next = shifted[DATA_W-1:0];
        end
    end

    always_comb begin
        prod_valid_next = prod_valid_reg;
        if (res_valid && res_ready) begin
            prod_valid_next = 1'b1;
        end else if (out_free) begin
            prod_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (prod_valid_reg && out_free) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg && out_free) begin
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    `ASSERT_NEXT(a_prod_reaches_out, prod_valid_reg && out_free, out_valid_reg)
    `ASSERT_SAME(a_relu_nonneg, out_valid_reg && cfg.relu && $stable(cfg.relu), !out_value_reg[DATA_W-1])

endmodule

// ===== dv/tb_int8_dense_neuron_requant_core.sv =====
module tb_int8_dense_neuron_requant_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dnr_pkg::*;

    // Cycles to let the pipeline settle after the last expected result
    localparam int SETTLE_CYCLES = 8;
    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    // One tile as the sender sees it
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] weight;
        logic [LANES-1:0][DATA_W-1:0] act;
        logic [ACC_W-1:0]             bias;
        logic                         first;
        logic                         last;
    } tile_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [DATA_W-1:0]   s_weight_lane0 = '0;
    logic signed [DATA_W-1:0]   s_weight_lane1 = '0;
    logic signed [DATA_W-1:0]   s_weight_lane2 = '0;
    logic signed [DATA_W-1:0]   s_weight_lane3 = '0;
    logic signed [DATA_W-1:0]   s_act_lane0 = '0;
    logic signed [DATA_W-1:0]   s_act_lane1 = '0;
    logic signed [DATA_W-1:0]   s_act_lane2 = '0;
    logic signed [DATA_W-1:0]   s_act_lane3 = '0;
    logic signed [ACC_W-1:0]    s_neuron_bias = '0;
    logic                       s_first_tile = 1'b0;
    logic                       s_last_tile = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [DATA_W-1:0]   m_neuron_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [ACC_W-1:0]           cfg_data = '0;

    // Predictor state: accumulator and requantization settings
    logic [ACC_W-1:0]           acc_model = '0;
    logic [ACC_W-1:0]           mult_model = 32'd1;
    logic [SHIFT_W-1:0]         shift_model = '0;
    logic                       relu_model = 1'b0;

    logic signed [DATA_W-1:0]   expected_neuron_q[$];
    int                         mismatch_count = 0;
    int                         tiles_sent = 0;

    // Sender burst control
    bit                         gap_enable = 1'b1;
    int                         burst_left = 0;

    // Receiver stall pattern
    rx_mode_t                   rx_mode = RX_OPEN;
    int                         rx_left = 0;

    int8_dense_neuron_requant_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_weight_lane0 (s_weight_lane0),
        .s_weight_lane1 (s_weight_lane1),
        .s_weight_lane2 (s_weight_lane2),
        .s_weight_lane3 (s_weight_lane3),
        .s_act_lane0    (s_act_lane0),
        .s_act_lane1    (s_act_lane1),
        .s_act_lane2    (s_act_lane2),
        .s_act_lane3    (s_act_lane3),
        .s_neuron_bias  (s_neuron_bias),
        .s_first_tile   (s_first_tile),
        .s_last_tile    (s_last_tile),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_neuron_out   (m_neuron_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Run limit, far above the slowest legal run
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // Accumulate one tile; on a last tile return the requantized neuron output
    task automatic accumulate_tile(input tile_t t, output bit has_out,
                                   output logic signed [DATA_W-1:0] neuron);
        int                       lane_sum;
        logic [ACC_W-1:0]         prod;
        logic signed [ACC_W-1:0]  shifted;
        int                       val;
        lane_sum = 0;
        for (int k = 0; k < LANES; k++) begin
            lane_sum = lane_sum + $signed(t.weight[k]) * $signed(t.act[k]);
        end
        if (t.first) begin
            acc_model = t.bias;
        end
        acc_model = acc_model + lane_sum;
        has_out = t.last;
        neuron = '0;
        if (t.last) begin
            // Product wraps to 32 bits, then arithmetic shift
            prod = acc_model * mult_model;
            shifted = $signed(prod) >>> shift_model;
            val = shifted;
            if (relu_model && val < 0) begin
                val = 0;
            end
            if (val > SAT_HIGH) begin
                val = SAT_HIGH;
            end
            if (val < SAT_LOW) begin
                val = SAT_LOW;
            end
            neuron = DATA_W'(val);
        end
    endtask

    // Send one tile, honoring the burst/gap pattern, and predict on acceptance
    task automatic send_tile(input tile_t t);
        int                       gap;
        bit                       has_out;
        logic signed [DATA_W-1:0] neuron;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap_enable && gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_weight_lane0 <= t.weight[0];
        s_weight_lane1 <= t.weight[1];
        s_weight_lane2 <= t.weight[2];
        s_weight_lane3 <= t.weight[3];
        s_act_lane0    <= t.act[0];
        s_act_lane1    <= t.act[1];
        s_act_lane2    <= t.act[2];
        s_act_lane3    <= t.act[3];
        s_neuron_bias  <= t.bias;
        s_first_tile   <= t.first;
        s_last_tile    <= t.last;
        do @(posedge aclk); while (!s_ready);
        accumulate_tile(t, has_out, neuron);
        if (has_out) begin
            expected_neuron_q.push_back(neuron);
        end
        tiles_sent++;
    endtask

    // Stop sending and wait until every expected output has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_neuron_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_OUTPUT_MULTIPLIER:   mult_model = data;
            CFG_OUTPUT_SHIFT_AMOUNT: shift_model = data[SHIFT_W-1:0];
            CFG_RELU_ENABLE:         relu_model = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_requant(input logic [ACC_W-1:0] mult, input logic [ACC_W-1:0] shift,
                               input logic [ACC_W-1:0] relu);
        drain();
        cfg_write(CFG_OUTPUT_MULTIPLIER, mult);
        cfg_write(CFG_OUTPUT_SHIFT_AMOUNT, shift);
        cfg_write(CFG_RELU_ENABLE, relu);
    endtask

    function automatic tile_t make_tile(input logic [7:0] w0, w1, w2, w3,
                                        input logic [7:0] a0, a1, a2, a3,
                                        input logic [ACC_W-1:0] bias,
                                        input logic first, input logic last);
        tile_t t;
        t.weight[0] = w0;
        t.weight[1] = w1;
        t.weight[2] = w2;
        t.weight[3] = w3;
        t.act[0] = a0;
        t.act[1] = a1;
        t.act[2] = a2;
        t.act[3] = a3;
        t.bias = bias;
        t.first = first;
        t.last = last;
        return t;
    endfunction

    // Random tile: mostly random lanes, some zero padding, some extremes
    function automatic tile_t rand_tile(input logic first, input logic last);
        tile_t t;
        int    pick;
        int    used;
        pick = $urandom_range(0, 15);
        used = (pick < 3) ? $urandom_range(1, LANES - 1) : LANES;
        for (int k = 0; k < LANES; k++) begin
            if (pick == 15) begin
                t.weight[k] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
                t.act[k]    = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            end else begin
                t.weight[k] = (k < used) ? 8'($urandom) : 8'h00;
                t.act[k]    = 8'($urandom);
            end
        end
        case ($urandom_range(0, 3))
            0:       t.bias = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       t.bias = 32'($signed(16'($urandom)));
            default: t.bias = $urandom;
        endcase
        t.first = first;
        t.last = last;
        return t;
    endfunction

    // Receiver: ready pattern switches at random between open, coin, sparse and bursty modes
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= $urandom_range(0, 1);
            RX_SPARSE: m_ready <= (rx_left % 4 == 0);
            RX_BURSTY: m_ready <= (rx_left % 12 < 3);
            default:   m_ready <= 1'b1;
        endcase
    end

    // Output checker
    always @(posedge aclk) begin
        logic signed [DATA_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_neuron_q.size() == 0) begin
                report_mismatch($sformatf("unexpected neuron_out %0d", m_neuron_out));
            end else begin
                want = expected_neuron_q.pop_front();
                if (m_neuron_out !== want) begin
                    report_mismatch($sformatf("neuron_out got %0d expected %0d",
                                              m_neuron_out, want));
                end
            end
        end
    end

    // Settings after reset: single-tile neurons, lane extremes, accumulator wrap
    task automatic test_reset_settings();
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'd5, 1, 1));
        send_tile(make_tile(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                            32'd0, 1, 1));
        send_tile(make_tile(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h80,
                            32'd0, 1, 1));
        send_tile(make_tile(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
                            32'hFFFF_FF00, 1, 1));
        // Accumulator wraps past the top of the signed range
        send_tile(make_tile(1, 0, 0, 0, 1, 0, 0, 0, 32'h7FFF_FFFF, 1, 1));
        send_tile(make_tile(8'hFF, 0, 0, 0, 1, 0, 0, 0, 32'h8000_0000, 1, 1));
    endtask

    // Multi-tile neurons, ignored bias, continuation without first, padding
    task automatic test_multi_tile();
        send_tile(make_tile(3, 8'hFE, 5, 1, 4, 7, 8'hF9, 2, 32'hFFFF_FFEC, 1, 0));
        send_tile(make_tile(2, 2, 2, 2, 3, 3, 3, 3, 32'd1000, 0, 0));
        send_tile(make_tile(1, 0, 0, 0, 8'h9C, 0, 0, 0, 32'hDEAD_BEEF, 0, 1));
        // No first after last: keeps accumulating from the old value
        send_tile(make_tile(10, 0, 0, 0, 10, 0, 0, 0, 32'h1234_5678, 0, 1));
        send_tile(make_tile(5, 8'hFB, 0, 0, 6, 6, 8'h80, 8'h7F, 32'd7, 1, 1));
    endtask

    // Requantization extremes: product wrap, full shift, ReLU, odd index
    task automatic test_requant_extremes();
        set_requant(32'h7FFF_FFFF, 32'd0, 32'd0);
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'd3, 1, 1));
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1));
        set_requant(32'h8000_0000, 32'hFFFF_FFE0, 32'd0);
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'd1, 1, 1));
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'd2, 1, 1));
        set_requant(32'd1, 32'h0000_001F, 32'hFFFF_FFFF);
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 1));
        send_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 1));
        set_requant(32'd1, 32'd4, 32'd1);
        send_tile(make_tile(8'h80, 0, 0, 0, 8'h7F, 0, 0, 0, 32'd0, 1, 1));
        send_tile(make_tile(8'h7F, 0, 0, 0, 8'h7F, 0, 0, 0, 32'd0, 1, 1));
        // Write to an index with no register behind it
        drain();
        cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_tile(make_tile(1, 1, 1, 1, 8'h20, 8'h20, 8'h20, 8'h20, 32'd16, 1, 1));
    endtask

    // Random neurons: mostly well formed, some continuations and restarts
    task automatic run_random_neurons(input int n_tiles);
        int stop_at;
        int len;
        int kind;
        stop_at = tiles_sent + n_tiles;
        while (tiles_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
            if (kind < 8) begin
                for (int i = 0; i < len; i++) begin
                    send_tile(rand_tile(i == 0, i == len - 1));
                end
            end else if (kind == 8) begin
                // Continue the previous neuron without a first tile
                for (int i = 0; i < len; i++) begin
                    send_tile(rand_tile(1'b0, i == len - 1));
                end
            end else begin
                // Abandoned neuron, restarted by a new first tile
                send_tile(rand_tile(1'b1, 1'b0));
                send_tile(rand_tile(1'b1, 1'b0));
                send_tile(rand_tile(1'b0, 1'b1));
            end
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
        end
    endtask

    // Random traffic under a sweep of requantization settings
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_requant(32'd1, 32'd6, 32'd0);
                1: set_requant($urandom_range(1, 16'hFFFF), $urandom_range(8, 16),
                               $urandom_range(0, 1));
                2: set_requant(32'h7FFF_FFFF, {27'($urandom), 5'd31}, 32'd1);
                3: set_requant(32'h8000_0000, 32'd0, 32'd0);
                4: set_requant($urandom, $urandom, $urandom);
                default: set_requant(32'd1, 32'd0, 32'd1);
            endcase
            gap_enable = (p != 3);
            run_random_neurons(70);
        end
        gap_enable = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_multi_tile();
        test_requant_extremes();
        test_random_phases();
        drain();
        if (mismatch_count == 0 && expected_neuron_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== int8_dense_neuron_requant_core.f =====
+incdir+hw/rtl
hw/rtl/dnr_pkg.sv
hw/rtl/dnr_lane.sv
hw/rtl/dnr_merge.sv
hw/rtl/dnr_requant.sv
hw/rtl/int8_dense_neuron_requant_core.sv
dv/tb_int8_dense_neuron_requant_core.sv
